[rtl/core/assert_macros.svh]
// assertion macros shared by the sms deliver decoder rtl
// assumes clk_i and rst_ni are visible in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SDPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define SDPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/core/sdpd_pkg.sv]
// types and constants shared by the sms deliver pdu decoder
// no dependencies
package sdpd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxRes = 3;

  localparam logic [2:0] KIND_CENTRE  = 3'd0;
  localparam logic [2:0] KIND_SENDER  = 3'd1;
  localparam logic [2:0] KIND_STAMP   = 3'd2;
  localparam logic [2:0] KIND_TEXT    = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
  } res_t;

  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      slots;
    logic            concatenated;
    logic [7:0]      concat_ref;
    logic [7:0]      concat_total;
    logic [7:0]      part_index;
    logic [7:0]      coding;
    logic [7:0]      user_length;
  } entry_t;

endpackage

[rtl/core/sms_deliver_pdu_decoder.sv]
// sms deliver pdu decoder, top level
// depends on sdpd_pkg, sdpd_front, sdpd_queue, sdpd_back
//
// input channel: one pdu octet per word on pdu_octet_i, end_of_pdu_i on the
// final octet, qualified by in_valid_i and held off by in_stall_o
// output channel: one result word per accepted out_valid_o with out_stall_i low;
// kind_o says centre, sender, stamp digit, text character or summary
// each octet yields zero to three words; the summary closes every pdu
// a word is written into the result queue, then registered at the back end output
// throughput: one octet per cycle while the queue is not full; the back end drains
// one word per cycle while out_stall_i is low and pops a bundle with its last word
// the result queue holds Depth bundles; in_stall_o rises when it is full
// a stall on the output backs up the queue and then the input, nothing is lost
// reset clears the field walk to the centre length and empties the queue
module sms_deliver_pdu_decoder #(
  parameter int unsigned Depth = sdpd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pdu_octet_i,
  input  logic        end_of_pdu_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] value_o,
  output logic        last_o,
  output logic        concatenated_o,
  output logic [7:0]  concat_ref_o,
  output logic [7:0]  concat_total_o,
  output logic [7:0]  part_index_o,
  output logic [7:0]  coding_o,
  output logic [7:0]  user_length_o
);
  import sdpd_pkg::*;

  entry_t entry, head;
  logic   push, pop, full, empty, accept;

  assign in_stall_o = full;
  assign accept = in_valid_i && !full;

  sdpd_front u_front (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .pdu_octet_i, .end_of_pdu_i,
    .entry_o(entry),
    .push_o(push)
  );

  sdpd_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .entry_i(entry),
    .pop_i(pop), .head_o(head),
    .full_o(full), .empty_o(empty)
  );

  sdpd_back u_back (
    .clk_i, .rst_ni,
    .head_i(head), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_stall_i,
    .kind_o, .value_o, .last_o, .concatenated_o,
    .concat_ref_o, .concat_total_o, .part_index_o,
    .coding_o, .user_length_o
  );

endmodule

[rtl/core/sdpd_front.sv]
// front end: walks the pdu fields one accepted octet per cycle and bundles its results
// depends on sdpd_pkg
module sdpd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     pdu_octet_i,
  input  logic           end_of_pdu_i,
  output sdpd_pkg::entry_t entry_o,
  output logic           push_o
);
  import sdpd_pkg::*;

  typedef enum logic [3:0] {
    PH_SC_LEN, PH_SC_TYPE, PH_SC_DIGITS, PH_FIRST, PH_OA_LEN, PH_OA_TYPE,
    PH_OA_DIGITS, PH_PID, PH_DCS, PH_TS, PH_UDL, PH_UD
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      left_q, left_d;
  logic            hh_q, hh_d;
  logic [7:0]      coding_q, coding_d;
  logic [7:0]      ulen_q, ulen_d;
  logic [7:0]      hlen_q, hlen_d;
  logic [7:0]      uoi_q, uoi_d;
  logic [3:0][7:0] hf_q, hf_d;
  logic [2:0]      off_q, off_d;
  logic [7:0]      prev_q, prev_d;
  logic [8:0]      skip_q, skip_d;
  logic [8:0]      emit_q, emit_d;
  logic [7:0]      hb_q, hb_d;

  entry_t          e;
  logic [11:0]     hdr_bits;
  logic [24:0]     hdr_prod;

  assign hdr_bits = {1'b0, pdu_octet_i, 3'b000} + 12'd14;
  assign hdr_prod = {13'd0, hdr_bits} * 25'd4682;

  always_comb begin
    logic [7:0]  o;
    logic [7:0]  i;
    logic        wide;
    logic        inhdr;
    logic [7:0]  base;
    logic [7:0]  rel;
    logic        par;
    logic [15:0] pair;
    logic [15:0] ch;
    logic [6:0]  s;
    logic [3:0]  offn;
    logic [1:0]  n;

    o = pdu_octet_i;
    i = uoi_q;
    wide = 1'b0;
    inhdr = 1'b0;
    base = 8'd3;
    rel = 8'd0;
    par = 1'b0;
    pair = 16'd0;
    ch = 16'd0;
    s = 7'd0;
    offn = 4'd0;
    n = 2'd0;
    e = '0;

    phase_d = phase_q;
    left_d = left_q;
    hh_d = hh_q;
    coding_d = coding_q;
    ulen_d = ulen_q;
    hlen_d = hlen_q;
    uoi_d = uoi_q;
    hf_d = hf_q;
    off_d = off_q;
    prev_d = prev_q;
    skip_d = skip_q;
    emit_d = emit_q;
    hb_d = hb_q;

    case (phase_q)
      PH_SC_LEN: begin
        if (o == 8'd0) begin
          phase_d = PH_FIRST;
        end else begin
          left_d = o - 8'd1;
          phase_d = PH_SC_TYPE;
        end
      end
      PH_SC_TYPE: phase_d = (left_q != 8'd0) ? PH_SC_DIGITS : PH_FIRST;
      PH_SC_DIGITS, PH_OA_DIGITS, PH_TS: begin
        e.slots[n].kind = (phase_q == PH_SC_DIGITS) ? KIND_CENTRE :
                          (phase_q == PH_OA_DIGITS) ? KIND_SENDER : KIND_STAMP;
        e.slots[n].value = {12'd0, o[3:0]};
        n = n + 2'd1;
        if (o[7:4] != 4'hF) begin
          e.slots[n].kind = e.slots[0].kind;
          e.slots[n].value = {12'd0, o[7:4]};
          n = n + 2'd1;
        end
        left_d = left_q - 8'd1;
        if (left_d == 8'd0) begin
          phase_d = (phase_q == PH_SC_DIGITS) ? PH_FIRST :
                    (phase_q == PH_OA_DIGITS) ? PH_PID : PH_UDL;
        end
      end
      PH_FIRST: begin
        hh_d = o[6];
        phase_d = PH_OA_LEN;
      end
      PH_OA_LEN: begin
        left_d = 8'(({1'b0, o} + 9'd1) >> 1);
        phase_d = PH_OA_TYPE;
      end
      PH_OA_TYPE: phase_d = (left_q != 8'd0) ? PH_OA_DIGITS : PH_PID;
      PH_PID: phase_d = PH_DCS;
      PH_DCS: begin
        coding_d = o;
        left_d = 8'd7;
        phase_d = PH_TS;
      end
      PH_UDL: begin
        ulen_d = o;
        phase_d = PH_UD;
      end
      PH_UD: begin
        wide = (coding_q == 8'd8);
        if (!(wide && i >= ulen_q)) begin
          if (hh_q && i == 8'd0) begin
            hlen_d = o;
            if (!wide) skip_d = hdr_prod[23:15];
          end
          inhdr = hh_q && (i <= hlen_d);
          if (hh_q && i >= 8'd1 && i <= hlen_d) begin
            if (i == 8'd1) begin
              hf_d[0] = o;
            end else begin
              base = (hf_q[0] == 8'd8) ? 8'd4 : 8'd3;
              if (i >= base && i <= base + 8'd2) begin
                rel = i - base + 8'd1;
                hf_d[rel[1:0]] = o;
              end
            end
          end
          if (wide) begin
            if (!inhdr) begin
              par = i[0] ^ (hh_q & ~hlen_d[0]);
              if (!par) begin
                hb_d = o;
              end else begin
                ch = {hb_q, o};
                e.slots[n].kind = KIND_TEXT;
                e.slots[n].value = (ch == 16'h0011) ? 16'h005F : ch;
                n = n + 2'd1;
              end
            end
          end else begin
            pair = {o, prev_q} >> (4'd8 - {1'b0, off_q});
            s = pair[6:0];
            if (emit_d < {1'b0, ulen_q}) begin
              if (emit_d >= skip_d) begin
                e.slots[n].kind = KIND_TEXT;
                e.slots[n].value = (s == 7'h11) ? 16'h005F : {9'd0, s};
                n = n + 2'd1;
              end
              emit_d = emit_d + 9'd1;
            end
            offn = {1'b0, off_q} + 4'd1;
            if (offn >= 4'd7) begin
              s = o[7:1];
              if (emit_d < {1'b0, ulen_q}) begin
                if (emit_d >= skip_d) begin
                  e.slots[n].kind = KIND_TEXT;
                  e.slots[n].value = (s == 7'h11) ? 16'h005F : {9'd0, s};
                  n = n + 2'd1;
                end
                emit_d = emit_d + 9'd1;
              end
              off_d = 3'd0;
            end else begin
              off_d = offn[2:0];
            end
            prev_d = o;
          end
          if (uoi_q != 8'd255) uoi_d = uoi_q + 8'd1;
        end
      end
      default: phase_d = PH_SC_LEN;
    endcase

    if (end_of_pdu_i) begin
      e.slots[n].kind = KIND_SUMMARY;
      e.slots[n].value = 16'd0;
      n = n + 2'd1;
      if (hh_d) begin
        e.concatenated = (hf_d[0] == 8'd0) || (hf_d[0] == 8'd8);
        e.concat_ref = hf_d[1];
        e.concat_total = hf_d[2];
        e.part_index = hf_d[3];
      end
      e.coding = coding_d;
      e.user_length = ulen_d;
      phase_d = PH_SC_LEN;
      left_d = '0;
      hh_d = 1'b0;
      coding_d = '0;
      ulen_d = '0;
      hlen_d = '0;
      uoi_d = '0;
      hf_d = '0;
      off_d = '0;
      prev_d = '0;
      skip_d = '0;
      emit_d = '0;
      hb_d = '0;
    end
    e.cnt = n;
  end

  assign entry_o = e;
  assign push_o = accept_i && (e.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SC_LEN;
      left_q <= '0;
      hh_q <= 1'b0;
      coding_q <= '0;
      ulen_q <= '0;
      hlen_q <= '0;
      uoi_q <= '0;
      hf_q <= '0;
      off_q <= '0;
      prev_q <= '0;
      skip_q <= '0;
      emit_q <= '0;
      hb_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q <= left_d;
      hh_q <= hh_d;
      coding_q <= coding_d;
      ulen_q <= ulen_d;
      hlen_q <= hlen_d;
      uoi_q <= uoi_d;
      hf_q <= hf_d;
      off_q <= off_d;
      prev_q <= prev_d;
      skip_q <= skip_d;
      emit_q <= emit_d;
      hb_q <= hb_d;
    end
  end

endmodule

[rtl/core/sdpd_queue.sv]
// short queue of result bundles between front and back
// depends on sdpd_pkg and assert_macros.svh
module sdpd_queue #(
  parameter int unsigned Depth = sdpd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sdpd_pkg::entry_t entry_i,
  input  logic             pop_i,
  output sdpd_pkg::entry_t head_o,
  output logic             full_o,
  output logic             empty_o
);
  import sdpd_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;

  assign head_o = mem_q[rptr_q];
  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `SDPD_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `SDPD_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from empty queue")

endmodule

[rtl/core/sdpd_back.sv]
// back end: unpacks queued bundles into one result word per cycle while out_stall_i is low
// depends on sdpd_pkg and assert_macros.svh
module sdpd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdpd_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       kind_o,
  output logic [15:0]      value_o,
  output logic             last_o,
  output logic             concatenated_o,
  output logic [7:0]       concat_ref_o,
  output logic [7:0]       concat_total_o,
  output logic [7:0]       part_index_o,
  output logic [7:0]       coding_o,
  output logic [7:0]       user_length_o
);
  import sdpd_pkg::*;
  `include "assert_macros.svh"

  logic [1:0] slot_q;
  logic       valid_q;
  logic       load;
  logic       is_last;
  logic       is_sum;
  res_t       cur;

  assign cur = head_i.slots[slot_q];
  assign load = !empty_i && (!valid_q || !out_stall_i);
  assign is_last = (slot_q == head_i.cnt - 2'd1);
  assign is_sum = (cur.kind == KIND_SUMMARY);
  assign pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      slot_q <= is_last ? 2'd0 : slot_q + 2'd1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o <= cur.kind;
      value_o <= cur.value;
      last_o <= is_last;
      concatenated_o <= is_sum ? head_i.concatenated : 1'b0;
      concat_ref_o <= is_sum ? head_i.concat_ref : 8'd0;
      concat_total_o <= is_sum ? head_i.concat_total : 8'd0;
      part_index_o <= is_sum ? head_i.part_index : 8'd0;
      coding_o <= is_sum ? head_i.coding : 8'd0;
      user_length_o <= is_sum ? head_i.user_length : 8'd0;
    end
  end

  assign out_valid_o = valid_q;

  `SDPD_ASSERT(a_sum_is_last,
    (out_valid_o && kind_o == KIND_SUMMARY) |-> last_o, "summary not last")
  `SDPD_ASSERT(a_plain_zero,
    (out_valid_o && kind_o != KIND_SUMMARY) |-> (coding_o == 8'd0 && !concatenated_o),
    "summary fields on non-summary word")

endmodule

[tb/tb_top.sv]
// self-checking testbench for sms_deliver_pdu_decoder: a clocked driver and monitor
// with random gaps on both sides, checked against a behavioral decoder model
// depends on sdpd_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb_top;
  import sdpd_pkg::*;

  typedef enum logic [3:0] {
    P_SC_LEN, P_SC_TYPE, P_SC_DIGITS, P_FIRST, P_OA_LEN, P_OA_TYPE, P_OA_DIGITS,
    P_PID, P_DCS, P_TS, P_UDL, P_UD
  } walk_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic        last;
    logic        concatenated;
    logic [7:0]  concat_ref;
    logic [7:0]  concat_total;
    logic [7:0]  part_index;
    logic [7:0]  coding;
    logic [7:0]  user_length;
  } word_t;

  typedef struct {
    logic [7:0] octet;
    logic        eop;
    logic        drain;
  } octet_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pdu_octet_i = 8'd0;
  logic        end_of_pdu_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [15:0] value_o;
  logic        last_o;
  logic        concatenated_o;
  logic [7:0]  concat_ref_o;
  logic [7:0]  concat_total_o;
  logic [7:0]  part_index_o;
  logic [7:0]  coding_o;
  logic [7:0]  user_length_o;

  sms_deliver_pdu_decoder dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  // decoder model state
  walk_e      ph;
  logic [7:0] left_q, dcs_q, udl_q, hlen_q, uidx_q, prev_q, hi_q;
  logic       hdr_q;
  logic [7:0] hf_q [4];
  logic [2:0] soff_q;
  logic [8:0] skip_q, emitted_q;

  word_t  expected_words [$];
  octet_t pending [$];
  word_t  outs [3];
  int     n_outs;
  int     errors = 0;

  function automatic void clear_decoder();
    ph = P_SC_LEN;
    left_q = 0; dcs_q = 0; udl_q = 0; hlen_q = 0; uidx_q = 0; prev_q = 0; hi_q = 0;
    hdr_q = 0; soff_q = 0; skip_q = 0; emitted_q = 0;
    for (int i = 0; i < 4; i++) hf_q[i] = 0;
  endfunction

  function automatic void put_word(logic [2:0] k, logic [15:0] v);
    if (n_outs < 3) begin
      outs[n_outs] = '0;
      outs[n_outs].kind = k;
      outs[n_outs].value = v;
      n_outs++;
    end
  endfunction

  function automatic void put_digits(logic [2:0] k, logic [7:0] o);
    put_word(k, {12'd0, o[3:0]});
    if (o[7:4] != 4'hF) put_word(k, {12'd0, o[7:4]});
  endfunction

  function automatic void put_char(logic [15:0] c);
    put_word(KIND_TEXT, (c == 16'h0011) ? 16'h005F : c);
  endfunction

  function automatic void take_septet(logic [6:0] s);
    if (emitted_q < udl_q) begin
      if (emitted_q >= skip_q) put_char({9'd0, s});
      emitted_q++;
    end
  endfunction

  function automatic void unpack(logic [7:0] o);
    int off;
    logic [6:0] s;
    off = soff_q;
    if (off == 0) s = o[6:0];
    else s = 7'((int'(o) << off) & 8'h7F) | 7'(int'(prev_q) >> (8 - off));
    take_septet(s);
    off++;
    if (off >= 7) begin
      take_septet(o[7:1]);
      off = 0;
    end
    soff_q = 3'(off);
    prev_q = o;
  endfunction

  function automatic void user_data(logic [7:0] o);
    int  i, base, d;
    logic wide, in_hdr;
    i = uidx_q;
    wide = (dcs_q == 8'h08);
    if (wide && i >= udl_q) return;
    if (hdr_q && i == 0) begin
      hlen_q = o;
      if (!wide) skip_q = 9'((((int'(o) + 1) * 8) + 6) / 7);
    end
    in_hdr = hdr_q && i <= hlen_q;
    if (hdr_q && i >= 1 && i <= hlen_q) begin
      if (i == 1) hf_q[0] = o;
      else begin
        base = (hf_q[0] == 8'h08) ? 4 : 3;
        if (i >= base && i <= base + 2) hf_q[1 + i - base] = o;
      end
    end
    if (wide) begin
      if (!in_hdr) begin
        d = i - (hdr_q ? int'(hlen_q) + 1 : 0);
        if (d % 2 == 0) hi_q = o;
        else put_char({hi_q, o});
      end
    end else unpack(o);
    if (uidx_q < 8'd255) uidx_q++;
  endfunction

  function automatic void predict(logic [7:0] o, logic eop);
    int k;
    n_outs = 0;
    case (ph)
      P_SC_LEN: begin
        if (o == 0) ph = P_FIRST;
        else begin
          left_q = o - 1;
          ph = P_SC_TYPE;
        end
      end
      P_SC_TYPE: ph = (left_q != 0) ? P_SC_DIGITS : P_FIRST;
      P_SC_DIGITS: begin
        put_digits(KIND_CENTRE, o);
        left_q--;
        if (left_q == 0) ph = P_FIRST;
      end
      P_FIRST: begin
        hdr_q = o[6];
        ph = P_OA_LEN;
      end
      P_OA_LEN: begin
        left_q = 8'((int'(o) + 1) / 2);
        ph = P_OA_TYPE;
      end
      P_OA_TYPE: ph = (left_q != 0) ? P_OA_DIGITS : P_PID;
      P_OA_DIGITS: begin
        put_digits(KIND_SENDER, o);
        left_q--;
        if (left_q == 0) ph = P_PID;
      end
      P_PID: ph = P_DCS;
      P_DCS: begin
        dcs_q = o;
        left_q = 7;
        ph = P_TS;
      end
      P_TS: begin
        put_digits(KIND_STAMP, o);
        left_q--;
        if (left_q == 0) ph = P_UDL;
      end
      P_UDL: begin
        udl_q = o;
        ph = P_UD;
      end
      default: user_data(o);
    endcase
    if (eop) begin
      k = n_outs;
      put_word(KIND_SUMMARY, 16'd0);
      if (k < n_outs) begin
        if (hdr_q) begin
          outs[k].concatenated = (hf_q[0] == 0 || hf_q[0] == 8);
          outs[k].concat_ref = hf_q[1];
          outs[k].concat_total = hf_q[2];
          outs[k].part_index = hf_q[3];
        end
        outs[k].coding = dcs_q;
        outs[k].user_length = udl_q;
      end
      clear_decoder();
    end
    if (n_outs > 0) outs[n_outs - 1].last = 1'b1;
    for (int j = 0; j < n_outs; j++) expected_words.insert(expected_words.size(), outs[j]);
  endfunction

  // random octet for a semi-octet field, sometimes with the filler nibble
  function automatic logic [7:0] bcd_octet();
    logic [7:0] o;
    o = 8'($urandom);
    if ($urandom_range(0, 3) == 0) o[7:4] = 4'hF;
    return o;
  endfunction

  // builds one pdu; cut >= 0 truncates it to its first cut + 1 octets
  task automatic add_pdu(int sc, int oa, int dcs, int udl, bit hdr, int iei, int hlen,
                         int extra, int cut, bit drain);
    logic [7:0] b [$];
    int n, ud0;
    b.insert(b.size(), 8'(sc));
    if (sc > 0) b.insert(b.size(), 8'h91);
    for (int i = 1; i < sc; i++) b.insert(b.size(), bcd_octet());
    b.insert(b.size(), {1'($urandom), hdr, 6'($urandom)});
    b.insert(b.size(), 8'(oa));
    b.insert(b.size(), 8'($urandom));
    for (int i = 0; i < (oa + 1) / 2; i++) b.insert(b.size(), bcd_octet());
    b.insert(b.size(), 8'($urandom));
    b.insert(b.size(), 8'(dcs));
    for (int i = 0; i < 7; i++) b.insert(b.size(), bcd_octet());
    b.insert(b.size(), 8'(udl));
    ud0 = b.size();
    n = ((dcs == 8) ? udl : (udl * 7 + 7) / 8) + extra;
    for (int i = 0; i < n; i++)
      b.insert(b.size(), ($urandom_range(0, 15) == 0) ? 8'h11 : 8'($urandom));
    if (hdr && n > 0) b[ud0] = 8'(hlen);
    if (hdr && n > 1) b[ud0 + 1] = 8'(iei);
    if (cut >= 0 && cut < b.size()) b = b[0:cut];
    foreach (b[i])
      pending.insert(pending.size(), octet_t'{b[i], i == b.size() - 1, drain && i == 0});
  endtask

  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  int  in_gap = 0, out_gap = 0, tick = 0;
  bit  calm = 0;
  octet_t nxt;

  always @(posedge clk_i) begin
    tick++;
    if (tick % 97 == 0) calm = ($urandom_range(0, 3) == 0);
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict(pdu_octet_i, end_of_pdu_i);
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain && expected_words.size() > 0)) begin
          nxt = pending.pop_front();
          in_valid_i <= 1'b1;
          pdu_octet_i <= nxt.octet;
          end_of_pdu_i <= nxt.eop;
          in_gap = gap_len(calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  word_t got, want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{kind_o, value_o, last_o, concatenated_o, concat_ref_o, concat_total_o,
                part_index_o, coding_o, user_length_o};
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("unexpected word: %p", got);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("mismatch: expected %p, actual %p", want, got);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_gap = gap_len(calm);
        out_stall_i <= (out_gap > 0);
      end
    end
  end

  initial begin
    clear_decoder();
    // directed
    pending.insert(pending.size(), octet_t'{8'h00, 1'b1, 1'b0});
    pending.insert(pending.size(), octet_t'{8'hFF, 1'b1, 1'b0});
    add_pdu(0, 11, 0, 10, 1, 0, 5, 0, -1, 1);
    add_pdu(1, 0, 8, 9, 1, 8, 6, 1, -1, 0);
    add_pdu(8, 20, 8, 14, 0, 0, 0, 2, -1, 0);
    add_pdu(12, 255, 0, 20, 0, 0, 0, 0, 14, 0);
    add_pdu(3, 4, 255, 0, 0, 0, 0, 1, -1, 0);
    add_pdu(2, 5, 8, 255, 0, 0, 0, 45, 40, 1);
    add_pdu(2, 6, 0, 255, 1, 3, 255, -3, 40, 0);
    add_pdu(7, 1, 0, 30, 1, 8, 0, 0, 30, 0);
    add_pdu(255, 3, 0, 5, 0, 0, 0, 0, 9, 0);
    // random
    while (pending.size() < 420) begin
      if ($urandom_range(0, 9) == 0)
        pending.insert(pending.size(), octet_t'{8'($urandom), 1'($urandom), 1'b0});
      else
        add_pdu($urandom_range(0, 7), $urandom_range(0, 20),
                ($urandom_range(0, 2) == 0) ? 8 : (($urandom_range(0, 1) == 0) ? 0 :
                $urandom_range(0, 255)),
                $urandom_range(0, 40), $urandom_range(0, 1),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                (($urandom_range(0, 1) == 0) ? 0 : 8),
                $urandom_range(0, 8), $urandom_range(0, 3) - 1,
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : -1,
                $urandom_range(0, 9) == 0);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    errors += expected_words.size();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sdpd_pkg.sv
rtl/core/sdpd_front.sv
rtl/core/sdpd_queue.sv
rtl/core/sdpd_back.sv
rtl/core/sms_deliver_pdu_decoder.sv
tb/tb_top.sv
